// File: src/smr_pkg.sv
// Shared constants, types and helper functions for the spiral matrix reader.
`timescale 1ns / 1ps

package smr_pkg;

    // Matrix geometry and word size.
    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the streaming and configuration ports.
    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

    // Derived sizes.
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RDIM_W = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W = $clog2(MAX_COLS + 1);
    localparam int CNT_W  = $clog2(CELLS + 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_cell;
        logic read_issue;
        logic load_out;
    } dp_cmd_t;

    // Rows in use: zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [RDIM_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [RDIM_W-1:0] r;
        if (v == '0)
            r = RDIM_W'(1);
        else if (int'(v) > MAX_ROWS)
            r = RDIM_W'(MAX_ROWS);
        else
            r = RDIM_W'(v);
        return r;
    endfunction

    // Columns in use, clamped the same way.
    function automatic logic [CDIM_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [CDIM_W-1:0] r;
        if (v == '0)
            r = CDIM_W'(1);
        else if (int'(v) > MAX_COLS)
            r = CDIM_W'(MAX_COLS);
        else
            r = CDIM_W'(v);
        return r;
    endfunction

endpackage

// File: src/smr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module smr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// File: src/smr_ctrl.sv
// Controller state machine: input handshake, read sequencing and output valid.
`timescale 1ns / 1ps

module smr_ctrl
    import smr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_is_read,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_READ = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Commands to the datapath.
    always_comb
    begin
        cmd.write_cell = accept && !in_is_read;
        cmd.read_issue = accept && in_is_read;
        cmd.load_out   = (state_reg == ST_READ) && out_free;
    end

    // Next state: a read waits in ST_READ until the output register is free.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_is_read)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/smr_datapath.sv
// Datapath: dimension registers, write pointer, spiral walk, cell RAM and output register.
`timescale 1ns / 1ps

module smr_datapath
    import smr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  logic [VALUE_W-1:0]   value,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic [VALUE_W-1:0]   element,
    output logic                 last
);

    localparam logic [1:0] HEAD_RIGHT = 2'd0;
    localparam logic [1:0] HEAD_DOWN  = 2'd1;
    localparam logic [1:0] HEAD_LEFT  = 2'd2;
    localparam logic [1:0] HEAD_UP    = 2'd3;

    logic [CFG_W-1:0]  num_rows_reg, num_rows_next;
    logic [CFG_W-1:0]  num_cols_reg, num_cols_next;
    logic [ADDR_W-1:0] wptr_reg, wptr_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [1:0]        head_reg, head_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ROW_W-1:0]  bottom_reg, bottom_next;
    logic [COL_W-1:0]  left_reg, left_next;
    logic [COL_W-1:0]  right_reg, right_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              last_pend_reg, last_pend_next;
    logic [VALUE_W-1:0] element_reg;
    logic              last_reg;

    logic [RDIM_W-1:0] rows_used;
    logic [CDIM_W-1:0] cols_used;
    logic [RDIM_W-1:0] rows_restart;
    logic [CDIM_W-1:0] cols_restart;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  wptr_inc;
    logic [CNT_W-1:0]  count_inc;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic              restart;
    logic              cfg_hit;

    assign rows_used = clamp_rows(num_rows_reg);
    assign cols_used = clamp_cols(num_cols_reg);
    assign total     = CNT_W'(rows_used) * CNT_W'(cols_used);
    assign wptr_inc  = CNT_W'(wptr_reg) + CNT_W'(1);
    assign count_inc = count_reg + CNT_W'(1);
    assign rd_addr   = ADDR_W'(row_reg) * ADDR_W'(cols_used) + ADDR_W'(col_reg);
    assign cfg_hit   = cfg_we && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS);

    // Dimension registers and the values a restart must use.
    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (cfg_we && cfg_index == REG_NUM_ROWS)
            num_rows_next = cfg_data;
        if (cfg_we && cfg_index == REG_NUM_COLS)
            num_cols_next = cfg_data;
        rows_restart = clamp_rows(num_rows_next);
        cols_restart = clamp_cols(num_cols_next);
    end

    // Write pointer: wraps after a full matrix, cleared by a register write.
    always_comb
    begin
        wptr_next = wptr_reg;
        if (cfg_hit)
            wptr_next = '0;
        else if (cmd.write_cell)
            wptr_next = (wptr_inc >= total) ? '0 : wptr_inc[ADDR_W-1:0];
    end

    // Spiral walk: restart on any write or after the final element, step on other reads.
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        head_next      = head_reg;
        top_next       = top_reg;
        bottom_next    = bottom_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        count_next     = count_reg;
        last_pend_next = last_pend_reg;
        restart        = cfg_hit || cmd.write_cell;

        if (cmd.read_issue)
        begin
            last_pend_next = (count_inc >= total);
            count_next     = count_inc;
            if (count_inc >= total)
            begin
                restart = 1'b1;
            end
            else
            begin
                case (head_reg)
                    HEAD_RIGHT:
                    begin
                        if (col_reg < right_reg)
                            col_next = col_reg + COL_W'(1);
                        else
                        begin
                            top_next  = top_reg + ROW_W'(1);
                            head_next = HEAD_DOWN;
                            row_next  = row_reg + ROW_W'(1);
                        end
                    end
                    HEAD_DOWN:
                    begin
                        if (row_reg < bottom_reg)
                            row_next = row_reg + ROW_W'(1);
                        else
                        begin
                            right_next = right_reg - COL_W'(1);
                            head_next  = HEAD_LEFT;
                            col_next   = col_reg - COL_W'(1);
                        end
                    end
                    HEAD_LEFT:
                    begin
                        if (col_reg > left_reg)
                            col_next = col_reg - COL_W'(1);
                        else
                        begin
                            bottom_next = bottom_reg - ROW_W'(1);
                            head_next   = HEAD_UP;
                            row_next    = row_reg - ROW_W'(1);
                        end
                    end
                    HEAD_UP:
                    begin
                        if (row_reg > top_reg)
                            row_next = row_reg - ROW_W'(1);
                        else
                        begin
                            left_next = left_reg + COL_W'(1);
                            head_next = HEAD_RIGHT;
                            col_next  = col_reg + COL_W'(1);
                        end
                    end
                    default:
                    begin
                        head_next = HEAD_RIGHT;
                    end
                endcase
            end
        end

        if (restart)
        begin
            row_next    = '0;
            col_next    = '0;
            head_next   = HEAD_RIGHT;
            top_next    = '0;
            bottom_next = ROW_W'(rows_restart - RDIM_W'(1));
            left_next   = '0;
            right_next  = COL_W'(cols_restart - CDIM_W'(1));
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= CFG_W'(4);
            num_cols_reg  <= CFG_W'(4);
            wptr_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            head_reg      <= HEAD_RIGHT;
            top_reg       <= '0;
            bottom_reg    <= ROW_W'(clamp_rows(CFG_W'(4)) - RDIM_W'(1));
            left_reg      <= '0;
            right_reg     <= COL_W'(clamp_cols(CFG_W'(4)) - CDIM_W'(1));
            count_reg     <= '0;
            last_pend_reg <= 1'b0;
        end
        else
        begin
            num_rows_reg  <= num_rows_next;
            num_cols_reg  <= num_cols_next;
            wptr_reg      <= wptr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            head_reg      <= head_next;
            top_reg       <= top_next;
            bottom_reg    <= bottom_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            count_reg     <= count_next;
            last_pend_reg <= last_pend_next;
        end
    end

    // Cell storage, written in row-major order and read along the spiral.
    smr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write_cell),
        .waddr (wptr_reg),
        .wdata (DATA_WIDTH'($unsigned(value))),
        .re    (cmd.read_issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Output register, loaded once the read data has arrived and the slot is free.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            element_reg <= VALUE_W'(rd_data);
            last_reg    <= last_pend_reg;
        end
    end

    assign element = element_reg;
    assign last    = last_reg;

endmodule

// File: src/spiral_matrix_reader_unit.sv
// Top level of the spiral matrix reader: stream ports, controller and datapath.
`timescale 1ns / 1ps
//
// Input stream (in_*): tuser[0] is the command, tdata the value. A write item
// (command 0) stores the value as the next matrix element in row-major order
// and produces no result; a read item (command 1) returns the next element in
// clockwise spiral order on the output stream (out_*), with tlast high on the
// final element of the spiral, after which the walk starts over. Any write or
// dimension register write restarts the walk.
// Configuration channel (cfg_*): index 0 sets the row count, index 1 the
// column count; it is always ready and must only be used while the block idles.
// A write item leaves the input open for the next item. A read item first
// accesses the cell RAM, then loads the output register; the input stays
// closed until that load. The output register lets a read result wait while
// the next write is taken; a further read is taken but then holds the input
// closed until the register can be reloaded.
// If the receiver stalls, the result holds on out_tdata and out_tlast.
// Reset clears the walk, the write pointer and the output valid, and sets both
// dimensions to four; the matrix contents are undefined until written.
//

module spiral_matrix_reader_unit
    import smr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_tvalid,
    output logic                 in_tready,
    input  logic [31:0]          in_tdata,   // [31:0] value
    input  logic [0:0]           in_tuser,   // [0] cmd
    output logic                 out_tvalid,
    input  logic                 out_tready,
    output logic [31:0]          out_tdata,  // [31:0] element
    output logic                 out_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    smr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_tvalid),
        .in_is_read (in_tuser[0]),
        .in_ready   (in_tready),
        .out_valid  (out_tvalid),
        .out_ready  (out_tready),
        .cmd        (cmd)
    );

    smr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (in_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .element   (out_tdata),
        .last      (out_tlast)
    );

endmodule

// File: src/smr_checker.sv
// Port-level assertions for the spiral matrix reader, bound to the top level.
`timescale 1ns / 1ps

module smr_checker
    import smr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_tvalid,
    input logic        in_tready,
    input logic [0:0]  in_tuser,
    input logic        out_tvalid,
    input logic        out_tready,
    input logic [31:0] out_tdata,
    input logic        out_tlast
);

    // No result is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_tvalid)
        else $error("out_tvalid high during reset");

    // A stalled result stays offered with the same payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
        else $error("stalled result changed");

    // A write item completes and the input stays open.
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_tvalid && in_tready && !in_tuser[0] |=> in_tready)
        else $error("input closed after a write item");

    // A read item occupies the block for its RAM access.
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_tvalid && in_tready && in_tuser[0] |=> !in_tready)
        else $error("input open during a read access");

endmodule

bind spiral_matrix_reader_unit smr_checker u_smr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
);

// File: sim/spiral_matrix_reader_unit_test.sv
// Self-checking testbench for the spiral matrix reader: directed and random item streams.
`timescale 1ns / 1ps

module spiral_matrix_reader_unit_test;
    import smr_pkg::*;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // An index that names no register; writing it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

    localparam int IDLE_PCT      = 38;
    localparam int RANDOM_ITEMS  = 800;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CFG_PAUSE     = 4;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [1:0] {
        HEAD_RIGHT,
        HEAD_DOWN,
        HEAD_LEFT,
        HEAD_UP
    } heading_t;

    typedef struct {
        logic [31:0] element;
        logic        last;
    } spiral_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_tvalid;
    logic                 in_tready;
    logic [31:0]          in_tdata;   // [31:0] value
    logic [0:0]           in_tuser;   // [0] cmd
    logic                 out_tvalid;
    logic                 out_tready;
    logic [31:0]          out_tdata;  // [31:0] element
    logic                 out_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Shadow of the block: configuration, matrix copy and walk state.
    logic [CFG_W-1:0]  rows_code;
    logic [CFG_W-1:0]  cols_code;
    logic [31:0]       matrix_copy [CELLS];
    bit                cell_written [CELLS];
    logic [ADDR_W-1:0] fill_ptr;
    logic [ROW_W-1:0]  walk_row;
    logic [COL_W-1:0]  walk_col;
    heading_t          walk_heading;
    logic [ROW_W-1:0]  edge_top;
    logic [ROW_W-1:0]  edge_bottom;
    logic [COL_W-1:0]  edge_left;
    logic [COL_W-1:0]  edge_right;
    logic [CNT_W-1:0]  walked_count;

    spiral_word_t spiral_words_due[$];
    spiral_word_t due_word;
    int           mismatch_count;
    bit           no_idle;

    spiral_matrix_reader_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (in_tvalid),
        .in_tready  (in_tready),
        .in_tdata   (in_tdata),
        .in_tuser   (in_tuser),
        .out_tvalid (out_tvalid),
        .out_tready (out_tready),
        .out_tdata  (out_tdata),
        .out_tlast  (out_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Dimension in use: zero counts as one, anything above the maximum as the maximum.
    function automatic int dim_in_use(input logic [CFG_W-1:0] code, input int limit);
        if (code == '0)
            return 1;
        if (int'(code) > limit)
            return limit;
        return int'(code);
    endfunction

    function automatic int cell_total();
        return dim_in_use(rows_code, MAX_ROWS) * dim_in_use(cols_code, MAX_COLS);
    endfunction

    function automatic int spiral_cell();
        return int'(walk_row) * dim_in_use(cols_code, MAX_COLS) + int'(walk_col);
    endfunction

    function automatic void restart_spiral();
        walk_row     = '0;
        walk_col     = '0;
        walk_heading = HEAD_RIGHT;
        edge_top     = '0;
        edge_bottom  = ROW_W'(dim_in_use(rows_code, MAX_ROWS) - 1);
        edge_left    = '0;
        edge_right   = COL_W'(dim_in_use(cols_code, MAX_COLS) - 1);
        walked_count = '0;
    endfunction

    // Step to the next cell, turning clockwise at the shrinking edges.
    function automatic void step_spiral();
        case (walk_heading)
            HEAD_RIGHT:
                if (walk_col < edge_right)
                    walk_col++;
                else
                begin
                    edge_top++;
                    walk_heading = HEAD_DOWN;
                    walk_row++;
                end
            HEAD_DOWN:
                if (walk_row < edge_bottom)
                    walk_row++;
                else
                begin
                    edge_right--;
                    walk_heading = HEAD_LEFT;
                    walk_col--;
                end
            HEAD_LEFT:
                if (walk_col > edge_left)
                    walk_col--;
                else
                begin
                    edge_bottom--;
                    walk_heading = HEAD_UP;
                    walk_row--;
                end
            default:
                if (walk_row > edge_top)
                    walk_row--;
                else
                begin
                    edge_left++;
                    walk_heading = HEAD_RIGHT;
                    walk_col++;
                end
        endcase
    endfunction

    // Update the shadow for one accepted item and queue the word a read returns.
    function automatic void track_item(input logic cmd, input logic [31:0] value);
        spiral_word_t word;
        if (cmd == CMD_WRITE)
        begin
            matrix_copy[fill_ptr]  = value;
            cell_written[fill_ptr] = 1'b1;
            if (int'(fill_ptr) + 1 >= cell_total())
                fill_ptr = '0;
            else
                fill_ptr++;
            restart_spiral();
        end
        else
        begin
            word.element = matrix_copy[spiral_cell()];
            walked_count++;
            if (int'(walked_count) >= cell_total())
            begin
                word.last = 1'b1;
                restart_spiral();
            end
            else
            begin
                word.last = 1'b0;
                step_spiral();
            end
            spiral_words_due.push_back(word);
        end
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    // Send one item; a read that would land on a cell never written becomes a write.
    task automatic send_item(input logic cmd, input logic [31:0] value);
        logic sent_cmd;
        sent_cmd = cmd;
        if (cmd == CMD_READ && !cell_written[spiral_cell()])
            sent_cmd = CMD_WRITE;
        if (!no_idle)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        in_tvalid   <= 1'b1;
        in_tuser[0] <= sent_cmd;
        in_tdata    <= value;
        @(posedge clk);
        while (!in_tready)
            @(posedge clk);
        track_item(sent_cmd, value);
    endtask

    // Register write, only once every read word has come back and the block has settled.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] code);
        in_tvalid <= 1'b0;
        while (spiral_words_due.size() != 0)
            @(posedge clk);
        repeat (CFG_PAUSE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= code;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_NUM_ROWS)
            rows_code = code;
        else if (idx == REG_NUM_COLS)
            cols_code = code;
        else
            return;
        fill_ptr = '0;
        restart_spiral();
    endtask

    // A 2 x 3 matrix of extreme values, read through one full spiral and one step more.
    task automatic test_small_spiral();
        write_register(REG_NUM_ROWS, CFG_W'(2));
        write_register(REG_NUM_COLS, CFG_W'(3));
        send_item(CMD_WRITE, 32'h8000_0000);
        send_item(CMD_WRITE, 32'h7FFF_FFFF);
        send_item(CMD_WRITE, 32'h0000_0000);
        send_item(CMD_WRITE, 32'hFFFF_FFFF);
        send_item(CMD_WRITE, 32'h5555_5555);
        send_item(CMD_WRITE, 32'hAAAA_AAAA);
        repeat (7) send_item(CMD_READ, $urandom);
    endtask

    // Zero rows acts as one: every read is the last, and extra writes wrap onto the one cell.
    task automatic test_single_cell();
        write_register(REG_NUM_ROWS, CFG_W'(0));
        write_register(REG_NUM_COLS, CFG_W'(1));
        send_item(CMD_WRITE, 32'h1234_5678);
        send_item(CMD_READ, 32'hFFFF_FFFF);
        send_item(CMD_READ, 32'h0000_0000);
        send_item(CMD_WRITE, 32'hDEAD_BEEF);
        send_item(CMD_WRITE, 32'h0BAD_F00D);
        send_item(CMD_READ, $urandom);
    endtask

    // Oversized codes clamp to the maximum; an unknown index leaves the walk alone.
    task automatic test_dimension_clamp();
        write_register(REG_NUM_ROWS, CFG_W'(31));
        write_register(REG_NUM_COLS, CFG_W'(17));
        repeat (3) send_item(CMD_WRITE, $urandom);
        send_item(CMD_READ, $urandom);
        send_item(CMD_READ, $urandom);
        write_register(REG_UNUSED, CFG_W'(5));
        send_item(CMD_READ, $urandom);
    endtask

    // Mostly small dimensions, sometimes zero, larger ones up to the maximum, or beyond it.
    function automatic logic [CFG_W-1:0] pick_dim_code();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return CFG_W'($urandom_range(5, 1));
        if (roll < 78)
            return '0;
        if (roll < 88)
            return CFG_W'($urandom_range(31, 17));
        return CFG_W'($urandom_range(16, 6));
    endfunction

    // Random geometries: fill the matrix, then read spirals with the odd stray write.
    task automatic test_random_spirals();
        int sent;
        int reads;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(9) < 7)
                write_register(REG_NUM_ROWS, pick_dim_code());
            if ($urandom_range(9) < 7)
                write_register(REG_NUM_COLS, pick_dim_code());
            repeat (cell_total())
            begin
                if (sent < RANDOM_ITEMS)
                begin
                    no_idle = (sent >= 250 && sent < 400);
                    send_item(CMD_WRITE, $urandom);
                    sent++;
                end
            end
            reads = $urandom_range(2 * cell_total() + 2, 1);
            repeat (reads)
            begin
                if (sent < RANDOM_ITEMS)
                begin
                    no_idle = (sent >= 250 && sent < 400);
                    if ($urandom_range(15) == 0)
                        send_item(CMD_WRITE, $urandom);
                    else
                        send_item(CMD_READ, $urandom);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Result stall: the receiver drops ready at random except during the steady stretch.
    always @(posedge clk)
    begin
        if (no_idle)
            out_tready <= 1'b1;
        else
            out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare every accepted result with the oldest word due.
    always @(posedge clk)
    begin
        if (rst_n && out_tvalid && out_tready)
        begin
            if (spiral_words_due.size() == 0)
                note_mismatch("result with nothing due", 32'h0, out_tdata);
            else
            begin
                due_word = spiral_words_due.pop_front();
                if (out_tdata !== due_word.element)
                    note_mismatch("element", due_word.element, out_tdata);
                if (out_tlast !== due_word.last)
                    note_mismatch("last", 32'(due_word.last), 32'(out_tlast));
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n       <= 1'b0;
        in_tvalid   <= 1'b0;
        in_tdata    <= '0;
        in_tuser    <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        out_tready  <= 1'b0;
        no_idle     = 1'b0;
        mismatch_count = 0;
        rows_code   = CFG_W'(4);
        cols_code   = CFG_W'(4);
        fill_ptr    = '0;
        foreach (cell_written[i])
            cell_written[i] = 1'b0;
        restart_spiral();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_spiral();
        test_single_cell();
        test_dimension_clamp();
        test_random_spirals();

        in_tvalid <= 1'b0;
        while (spiral_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && spiral_words_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
src/smr_pkg.sv
src/smr_ram.sv
src/smr_ctrl.sv
src/smr_datapath.sv
src/spiral_matrix_reader_unit.sv
src/smr_checker.sv
sim/spiral_matrix_reader_unit_test.sv
